// ----- design/bcu_pkg.sv -----
package bcu_pkg;

    localparam int IN_W      = 7;
    localparam int COEF_W    = 18;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 4;
    localparam int N_W       = 5;
    localparam int FAC_W     = 5;
    localparam int PROD_W    = COEF_W + FAC_W;
    localparam int BIT_W     = $clog2(PROD_W);
    localparam int MAX_N_DEF = 20;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic next;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic kzero;
        logic last;
        logic div_last;
    } t_dp_sts;

endpackage

// ----- design/bcu_datapath.sv -----
module bcu_datapath #(
    parameter int MAX_N = bcu_pkg::MAX_N_DEF
) (
    input  logic                          i_clk,
    input  logic [bcu_pkg::IN_W-1:0]      i_choose_count,
    input  logic [bcu_pkg::IN_W-1:0]      i_set_size,
    input  bcu_pkg::t_dp_cmd              i_cmd,
    output bcu_pkg::t_dp_sts              o_sts,
    output logic [bcu_pkg::COEF_W-1:0]    o_coefficient,
    output logic [bcu_pkg::ST_W-1:0]      o_status
);

    localparam int IN_W   = bcu_pkg::IN_W;
    localparam int COEF_W = bcu_pkg::COEF_W;
    localparam int CNT_W  = bcu_pkg::CNT_W;
    localparam int N_W    = bcu_pkg::N_W;
    localparam int FAC_W  = bcu_pkg::FAC_W;
    localparam int PROD_W = bcu_pkg::PROD_W;
    localparam int BIT_W  = bcu_pkg::BIT_W;

    logic signed [IN_W:0]        k_s, n_s, nk_s, keff_s, max_s;
    logic                        invalid, range_err;
    logic [FAC_W-1:0]            fac;
    logic [PROD_W-1:0]           mul_w;
    logic [CNT_W:0]              trial;
    logic                        q_bit;
    logic [CNT_W-1:0]            rem_next;

    logic [bcu_pkg::ST_W-1:0]    r_status;
    logic [CNT_W-1:0]            r_k;
    logic [N_W-1:0]              r_n;
    logic [CNT_W-1:0]            r_i;
    logic [COEF_W-1:0]           r_acc;
    logic [PROD_W-1:0]           r_prod;
    logic [CNT_W-1:0]            r_rem;
    logic [BIT_W-1:0]            r_bit;
    logic [COEF_W-1:0]           r_out_coef;
    logic [bcu_pkg::ST_W-1:0]    r_out_status;

    always_comb begin
        k_s       = {i_choose_count[IN_W-1], i_choose_count};
        n_s       = {i_set_size[IN_W-1], i_set_size};
        max_s     = (IN_W+1)'(MAX_N);
        nk_s      = n_s - k_s;
        keff_s    = (k_s > nk_s) ? nk_s : k_s;
        invalid   = (k_s < 0) || (n_s < k_s);
        range_err = n_s > max_s;
    end

    assign fac   = r_n - N_W'(r_k) + N_W'(r_i);
    assign mul_w = PROD_W'(r_acc) * PROD_W'(fac);

    always_comb begin
        trial    = {r_rem, r_prod[PROD_W-1]};
        q_bit    = trial >= {1'b0, r_i};
        rem_next = q_bit ? CNT_W'(trial - {1'b0, r_i}) : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (invalid) begin
                r_status <= bcu_pkg::ST_INVALID;
            end else if (range_err) begin
                r_status <= bcu_pkg::ST_RANGE;
            end else begin
                r_status <= bcu_pkg::ST_OK;
            end
            r_k   <= keff_s[CNT_W-1:0];
            r_n   <= n_s[N_W-1:0];
            r_i   <= CNT_W'(1);
            r_acc <= COEF_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= mul_w;
            r_rem  <= '0;
            r_bit  <= '0;
        end
        if (i_cmd.div) begin
            r_prod <= {r_prod[PROD_W-2:0], q_bit};
            r_rem  <= rem_next;
            r_bit  <= r_bit + BIT_W'(1);
        end
        if (i_cmd.next) begin
            r_acc <= r_prod[COEF_W-1:0];
            r_i   <= r_i + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_coef   <= (r_status == bcu_pkg::ST_OK) ? r_acc : '0;
            r_out_status <= r_status;
        end
    end

    assign o_sts.bad      = r_status != bcu_pkg::ST_OK;
    assign o_sts.kzero    = r_k == '0;
    assign o_sts.last     = r_i == r_k;
    assign o_sts.div_last = r_bit == BIT_W'(PROD_W - 1);

    assign o_coefficient = r_out_coef;
    assign o_status      = r_out_status;

endmodule

// ----- design/bcu_controller.sv -----
module bcu_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bcu_pkg::t_dp_sts  i_sts,
    output bcu_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_NEXT,
        S_PUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul      = r_state == S_MUL;
        o_cmd.div      = r_state == S_DIV;
        o_cmd.next     = r_state == S_NEXT;
        o_cmd.out_load = (r_state == S_PUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.bad || i_sts.kzero) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (i_sts.last) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ----- design/binomial_coefficient_unit.sv -----
// Binomial coefficient unit: returns C(n,k) and a status for each request.
// The slave channel carries one request per transfer: choose_count (k) and
// set_size (n), both signed. The master channel returns one result per
// request: the coefficient and a status (ok, invalid operands, n too large).
// Invalid operands (k negative or above n) and n above MAX_N give a zero
// coefficient. The unit works on one request at a time. For an accepted request
// that needs a product, each of up to ten factors, min(k, n-k) in all, costs
// one multiply, a restoring division by the step index on the shared
// divider, and one update. The result sits in an output register, so a new
// request is taken as soon as the result is loaded, even while the receiver
// still stalls; a finished second result then waits until the first one
// has been taken. Synchronous reset drops any request in progress and any
// result not yet taken.
module binomial_coefficient_unit #(
    parameter int MAX_N = bcu_pkg::MAX_N_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: choose_count[6:0], set_size[13:7], zero fill.
    input  logic [bcu_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: coefficient[17:0], status[19:18], zero fill.
    output logic [bcu_pkg::M_DATA_W-1:0]    m_axis_tdata
);

    localparam int IN_W   = bcu_pkg::IN_W;
    localparam int COEF_W = bcu_pkg::COEF_W;
    localparam int ST_W   = bcu_pkg::ST_W;

    bcu_pkg::t_dp_cmd    cmd;
    bcu_pkg::t_dp_sts    sts;
    logic [COEF_W-1:0]   coefficient;
    logic [ST_W-1:0]     status;

    bcu_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bcu_datapath #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk          (i_clk),
        .i_choose_count (s_axis_tdata[IN_W-1:0]),
        .i_set_size     (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_coefficient  (coefficient),
        .o_status       (status)
    );

    assign m_axis_tdata = {{(bcu_pkg::M_DATA_W - COEF_W - ST_W){1'b0}}, status, coefficient};

endmodule

// ----- tb/sv/binomial_coefficient_unit_test.sv -----
`timescale 1ns / 1ps
module binomial_coefficient_unit_test;

    localparam int IN_W         = bcu_pkg::IN_W;
    localparam int COEF_W       = bcu_pkg::COEF_W;
    localparam int ST_W         = bcu_pkg::ST_W;
    localparam int S_DATA_W     = bcu_pkg::S_DATA_W;
    localparam int M_DATA_W     = bcu_pkg::M_DATA_W;
    localparam int MAX_N        = bcu_pkg::MAX_N_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 300;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [COEF_W-1:0] coefficient;
    } t_choice;

    typedef struct {
        logic signed [IN_W-1:0] choose_count;
        logic signed [IN_W-1:0] set_size;
        bit                     typed;
        t_choice                answer;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] req_data = '0;
    logic                m_axis_tvalid;
    logic                res_ready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    t_choice pending_answers[$];
    t_row    directed_rows[$];
    int      failures = 0;
    int      results_seen = 0;
    int      ok_seen = 0;
    int      invalid_seen = 0;
    int      range_seen = 0;
    int      idle_cycles = 0;
    int      ready_hold = 0;
    bit      steady = 1'b1;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    binomial_coefficient_unit #(
        .MAX_N(MAX_N)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(req_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (req_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(res_ready),
        .m_axis_tdata (m_axis_tdata)
    );

    function automatic t_choice choose_coefficient(input logic signed [IN_W-1:0] k_in,
                                                   input logic signed [IN_W-1:0] n_in);
        int              k;
        int              n;
        longint unsigned acc;
        t_choice         r;
        k = k_in;
        n = n_in;
        acc = 1;
        r = '0;
        if (k < 0 || n < k) begin
            r.status = bcu_pkg::ST_INVALID;
        end else if (n > MAX_N) begin
            r.status = bcu_pkg::ST_RANGE;
        end else begin
            r.status = bcu_pkg::ST_OK;
            if (k > n - k) begin
                k = n - k;
            end
            for (int i = 1; i <= k; i++) begin
                acc = acc * longint'(n - k + i) / longint'(i);
            end
            r.coefficient = acc[COEF_W-1:0];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic signed [IN_W-1:0] k, input logic signed [IN_W-1:0] n,
                           input bit typed, input logic [COEF_W-1:0] coefficient,
                           input logic [ST_W-1:0] status);
        t_row row;
        row.choose_count       = k;
        row.set_size           = n;
        row.typed              = typed;
        row.answer.coefficient = coefficient;
        row.answer.status      = status;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic signed [IN_W-1:0] k,
                                input logic signed [IN_W-1:0] n, input t_choice answer);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(S_DATA_W - 2 * IN_W){1'b0}}, n, k};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(answer);
    endtask

    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (steady || $urandom_range(0, 2) != 0) begin
            res_ready  <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end else begin
            res_ready  <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_choice got;
        t_choice want;
        if (i_rst_n && m_axis_tvalid && res_ready) begin
            got = m_axis_tdata[COEF_W+ST_W-1:0];
            results_seen++;
            if (pending_answers.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("Unexpected result transfer: coefficient %0d status %0d",
                             got.coefficient, got.status);
                end
            end else begin
                want = pending_answers.pop_front();
                case (want.status)
                    bcu_pkg::ST_OK:      ok_seen++;
                    bcu_pkg::ST_INVALID: invalid_seen++;
                    default:             range_seen++;
                endcase
                if (got.coefficient !== want.coefficient || got.status !== want.status) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("Result %0d mismatch: coefficient %0d (expected %0d), %s%0d %s%0d",
                                 results_seen, got.coefficient, want.coefficient,
                                 "status ", got.status, "expected ", want.status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && s_axis_tready) || (m_axis_tvalid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("binomial_coefficient_unit_test failed");
                $finish;
            end
        end
    end

    initial begin
        int                     r;
        logic signed [IN_W-1:0] k;
        logic signed [IN_W-1:0] n;
        add_row(0, 0, 1, 1, bcu_pkg::ST_OK);
        add_row(0, 20, 1, 1, bcu_pkg::ST_OK);
        add_row(20, 20, 1, 1, bcu_pkg::ST_OK);
        add_row(1, 1, 1, 1, bcu_pkg::ST_OK);
        add_row(2, 2, 1, 1, bcu_pkg::ST_OK);
        add_row(1, 20, 1, 20, bcu_pkg::ST_OK);
        add_row(10, 20, 1, 184756, bcu_pkg::ST_OK);
        add_row(9, 20, 0, 0, bcu_pkg::ST_OK);
        add_row(11, 20, 0, 0, bcu_pkg::ST_OK);
        add_row(3, 7, 0, 0, bcu_pkg::ST_OK);
        add_row(17, 19, 0, 0, bcu_pkg::ST_OK);
        add_row(-1, 5, 1, 0, bcu_pkg::ST_INVALID);
        add_row(-64, -64, 1, 0, bcu_pkg::ST_INVALID);
        add_row(63, -64, 1, 0, bcu_pkg::ST_INVALID);
        add_row(-64, 63, 1, 0, bcu_pkg::ST_INVALID);
        add_row(5, 3, 1, 0, bcu_pkg::ST_INVALID);
        add_row(0, -1, 1, 0, bcu_pkg::ST_INVALID);
        add_row(21, 20, 1, 0, bcu_pkg::ST_INVALID);
        add_row(0, 21, 1, 0, bcu_pkg::ST_RANGE);
        add_row(21, 21, 1, 0, bcu_pkg::ST_RANGE);
        add_row(1, 63, 1, 0, bcu_pkg::ST_RANGE);
        add_row(63, 63, 1, 0, bcu_pkg::ST_RANGE);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].choose_count, directed_rows[i].set_size,
                         directed_rows[i].typed ? directed_rows[i].answer :
                         choose_coefficient(directed_rows[i].choose_count,
                                            directed_rows[i].set_size));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = ((i / 100) % 4) == 1;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = (r < 50) ? IN_W'($urandom_range(0, 12)) : IN_W'($urandom_range(0, MAX_N));
                k = IN_W'($urandom_range(0, n));
            end else if (r < 80) begin
                n = IN_W'($urandom_range(0, MAX_N));
                k = $urandom_range(0, 1) ? n : '0;
            end else begin
                k = IN_W'($urandom);
                n = IN_W'($urandom);
            end
            send_request(k, n, choose_coefficient(k, n));
        end
        steady = 1'b0;
        @(negedge i_clk);
        req_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d valid coefficients, %0d invalid operand pairs, %0d %s",
                 results_seen, ok_seen, invalid_seen, range_seen, "with n above the limit.");
        $display("Mismatches or unexpected results: %0d.", failures);
        if (failures == 0 && pending_answers.size() == 0) begin
            $display("binomial_coefficient_unit_test passed");
        end else begin
            $display("binomial_coefficient_unit_test failed");
        end
        $finish;
    end
endmodule
